FILE: hdl/cbs_pkg.sv
package cbs_pkg;

  typedef struct packed {
    logic load;
    logic clear;
    logic div_start;
    logic walk_start;
    logic walk_step;
    logic sqrt_start;
  } cbs_cmd_t;

  typedef struct packed {
    logic div_done;
    logic walk_done;
    logic sqrt_done;
  } cbs_sts_t;

endpackage

FILE: hdl/cbs_datapath.sv
module cbs_datapath #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16,
  parameter int CNT_BITS   = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cbs_pkg::cbs_cmd_t            cmd,
  output cbs_pkg::cbs_sts_t            sts,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] pz,
  output logic signed [COORD_BITS-1:0] cx,
  output logic signed [COORD_BITS-1:0] cy,
  output logic signed [COORD_BITS-1:0] cz,
  output logic [COORD_BITS:0]          radius,
  output logic [CNT_BITS-1:0]          count,
  output logic                         dropped
);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SW = COORD_BITS + CNT_BITS;
  localparam int DW = 2 * COORD_BITS + 4;
  localparam int RW = COORD_BITS + 1;
  localparam int QW = SW;

  logic [3*COORD_BITS-1:0] mem [MAX_POINTS];
  logic [3*COORD_BITS-1:0] rd_r;
  logic signed [SW-1:0] sx_r, sy_r, sz_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic drop_r;

  always_ff @(posedge clk) begin
    if (cmd.load && cnt_r < CNT_BITS'(MAX_POINTS))
      mem[cnt_r[AW-1:0]] <= {pz, py, px};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      sx_r <= '0; sy_r <= '0; sz_r <= '0; cnt_r <= '0; drop_r <= 1'b0;
    end else if (cmd.load) begin
      if (cnt_r < CNT_BITS'(MAX_POINTS)) begin
        sx_r <= sx_r + SW'(px);
        sy_r <= sy_r + SW'(py);
        sz_r <= sz_r + SW'(pz);
        cnt_r <= cnt_r + 1'b1;
      end else begin
        drop_r <= 1'b1;
      end
    end
  end

  // restoring division of the magnitude, three lanes in parallel
  logic [QW-1:0] qx_r, qy_r, qz_r, rx_r, ry_r, rz_r;
  logic nx_r, ny_r, nz_r;
  logic [$clog2(QW+1)-1:0] dcnt_r;
  logic dbusy_r;
  logic [QW:0] trx, tryy, trz;
  logic [QW-1:0] qxn, qyn, qzn;

  always_comb begin
    trx  = {rx_r, qx_r[QW-1]} - {{(QW+1-CNT_BITS){1'b0}}, cnt_r};
    tryy = {ry_r, qy_r[QW-1]} - {{(QW+1-CNT_BITS){1'b0}}, cnt_r};
    trz  = {rz_r, qz_r[QW-1]} - {{(QW+1-CNT_BITS){1'b0}}, cnt_r};
  end

  assign qxn = {qx_r[QW-2:0], ~trx[QW]};
  assign qyn = {qy_r[QW-2:0], ~tryy[QW]};
  assign qzn = {qz_r[QW-2:0], ~trz[QW]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r  <= '0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
      dcnt_r  <= '0;
      nx_r <= sx_r[SW-1]; ny_r <= sy_r[SW-1]; nz_r <= sz_r[SW-1];
      qx_r <= sx_r[SW-1] ? QW'(-sx_r) : QW'(sx_r);
      qy_r <= sy_r[SW-1] ? QW'(-sy_r) : QW'(sy_r);
      qz_r <= sz_r[SW-1] ? QW'(-sz_r) : QW'(sz_r);
      rx_r <= '0; ry_r <= '0; rz_r <= '0;
    end else if (dbusy_r) begin
      rx_r <= trx[QW] ? {rx_r[QW-2:0], qx_r[QW-1]} : trx[QW-1:0];
      ry_r <= tryy[QW] ? {ry_r[QW-2:0], qy_r[QW-1]} : tryy[QW-1:0];
      rz_r <= trz[QW] ? {rz_r[QW-2:0], qz_r[QW-1]} : trz[QW-1:0];
      qx_r <= qxn;
      qy_r <= qyn;
      qz_r <= qzn;
      dcnt_r <= dcnt_r + 1'b1;
      if (dcnt_r == $bits(dcnt_r)'(QW - 1)) dbusy_r <= 1'b0;
    end
  end

  assign sts.div_done = dbusy_r && dcnt_r == $bits(dcnt_r)'(QW - 1);

  logic signed [COORD_BITS-1:0] cx_r, cy_r, cz_r;
  always_ff @(posedge clk) begin
    if (sts.div_done) begin
      cx_r <= COORD_BITS'(nx_r ? -{1'b0, qxn} : {1'b0, qxn});
      cy_r <= COORD_BITS'(ny_r ? -{1'b0, qyn} : {1'b0, qyn});
      cz_r <= COORD_BITS'(nz_r ? -{1'b0, qzn} : {1'b0, qzn});
    end
  end

  // walk: address, read, subtract, square, sum/compare
  logic [CNT_BITS-1:0] wa_r;
  logic v0_r, v1_r, v2_r, wact_r;
  logic signed [COORD_BITS:0] dx_r, dy_r, dz_r;
  logic [2*COORD_BITS+1:0] qqx_r, qqy_r, qqz_r;
  logic [DW-1:0] best_r;
  logic [DW-1:0] dsum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wact_r <= 1'b0; v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0;
      wa_r <= '0;
    end else begin
      if (cmd.walk_start) begin
        wact_r <= 1'b1;
        wa_r <= '0;
      end else if (wact_r && cmd.walk_step) begin
        wa_r <= wa_r + 1'b1;
        if (wa_r == cnt_r - 1'b1) wact_r <= 1'b0;
      end
      v0_r <= wact_r && cmd.walk_step;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wact_r) rd_r <= mem[wa_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    dx_r <= (COORD_BITS+1)'(signed'(rd_r[COORD_BITS-1:0])) - (COORD_BITS+1)'(cx_r);
    dy_r <= (COORD_BITS+1)'(signed'(rd_r[2*COORD_BITS-1:COORD_BITS]))
            - (COORD_BITS+1)'(cy_r);
    dz_r <= (COORD_BITS+1)'(signed'(rd_r[3*COORD_BITS-1:2*COORD_BITS]))
            - (COORD_BITS+1)'(cz_r);
    qqx_r <= (2*COORD_BITS+2)'(dx_r * dx_r);
    qqy_r <= (2*COORD_BITS+2)'(dy_r * dy_r);
    qqz_r <= (2*COORD_BITS+2)'(dz_r * dz_r);
  end

  logic v3_r;
  assign dsum = DW'(qqx_r) + DW'(qqy_r) + DW'(qqz_r);
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    if (cmd.walk_start) best_r <= '0;
    else if (v2_r && dsum > best_r) best_r <= dsum;
  end
  // v0: rd_r, v1: dx, v2: qq, v3: best settled
  assign sts.walk_done = !wact_r && !v0_r && !v1_r && !v2_r && !v3_r;

  // bit-pair square root, one result bit a cycle
  logic [DW-1:0] sn_r, srem_r;
  logic [RW-1:0] sres_r;
  logic [$clog2(DW/2+1)-1:0] scnt_r;
  logic sbusy_r;
  logic [DW/2+2:0] strial;
  logic [DW/2+2:0] spart;
  assign spart  = {srem_r[DW/2:0], sn_r[DW-1:DW-2]};
  assign strial = spart - {{(DW/2+1-RW){1'b0}}, sres_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbusy_r <= 1'b0; scnt_r <= '0;
    end else if (cmd.sqrt_start) begin
      sbusy_r <= 1'b1; scnt_r <= '0;
      sn_r <= best_r; srem_r <= '0; sres_r <= '0;
    end else if (sbusy_r) begin
      sn_r <= sn_r << 2;
      if (!strial[DW/2+2]) begin
        srem_r <= DW'(strial);
        sres_r <= {sres_r[RW-2:0], 1'b1};
      end else begin
        srem_r <= DW'(spart);
        sres_r <= {sres_r[RW-2:0], 1'b0};
      end
      scnt_r <= scnt_r + 1'b1;
      if (scnt_r == $bits(scnt_r)'(DW/2 - 1)) sbusy_r <= 1'b0;
    end
  end
  assign sts.sqrt_done = sbusy_r && scnt_r == $bits(scnt_r)'(DW/2 - 1);

  assign cx = cx_r;
  assign cy = cy_r;
  assign cz = cz_r;
  assign radius = sres_r;
  assign count = cnt_r;
  assign dropped = drop_r;
endmodule

FILE: hdl/cbs_ctrl.sv
module cbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_last,
  input  logic              out_free,
  input  logic              out_fire,
  input  cbs_pkg::cbs_sts_t sts,
  output cbs_pkg::cbs_cmd_t cmd,
  output logic              in_rdy,
  output logic              out_load
);
  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_WST  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic go_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.div_start = go_r;
    out_load = 1'b0;
    in_rdy = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_rdy = 1'b1;
        cmd.load = in_fire;
        if (in_fire && in_last) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_WST;
      end
      S_WST: begin
        cmd.walk_start = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sts.sqrt_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free || out_fire) begin
          out_load = 1'b1;
          cmd.clear = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // division starts in the cycle after the last beat so the sums are settled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      go_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r <= in_fire && in_last && state_r == S_LOAD;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_LOAD) else $error("load outside load state");
  a_emit_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> state_r == S_LOAD) else $error("emit did not return");
  a_div_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> state_r == S_DIV) else $error("divide out of order");
`endif
endmodule

FILE: hdl/centroid_bounding_sphere_top.sv
// Centroid bounding sphere of a set of 3D points.
// Input channel in_*: one point per beat, tdata = px, py, pz (16-bit signed
// each), tuser = last. Points are stored and summed at one per cycle while
// in_tready is high. After the beat marked last the block stops accepting,
// divides the sums by the count (after a start, one quotient bit per
// cycle), walks the stored points (one memory read per cycle), then takes
// the floor square root of the largest squared distance (one root bit per
// cycle), and presents one result beat.
// Output channel out_*: tdata = center_x, center_y, center_z, radius_out,
// point_count, overflowed. The result sits in an output register; a stall
// on out_tready holds it, the next set still loads and computes, and its
// result waits until the register is free.
// Points beyond MAX_POINTS are dropped and flagged as overflowed.
// Reset clears the sums, count and flag; the point memory needs no clearing.
module centroid_bounding_sphere_top #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [3*COORD_BITS-1:0] in_tdata,   // px, py, pz
  input  logic                    in_tuser,   // last
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [((3*COORD_BITS+$clog2(MAX_POINTS+1)+COORD_BITS+2+7)/8)*8-1:0]
                                  out_tdata   // center_x, y, z, radius_out,
                                              // point_count, overflowed
);
  localparam int CNT_BITS = $clog2(MAX_POINTS + 1);
  localparam int OW = 3 * COORD_BITS + COORD_BITS + 1 + CNT_BITS + 1;
  localparam int OB = ((OW + 7) / 8) * 8;

  cbs_pkg::cbs_cmd_t cmd;
  cbs_pkg::cbs_sts_t sts;
  logic in_fire, out_fire, out_load;
  logic signed [COORD_BITS-1:0] cx, cy, cz;
  logic [COORD_BITS:0] radius;
  logic [CNT_BITS-1:0] count;
  logic dropped;
  logic ov_r;
  logic [OB-1:0] od_r;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  cbs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_last(in_tuser),
    .out_free(!ov_r), .out_fire(out_fire), .sts(sts), .cmd(cmd),
    .in_rdy(in_tready), .out_load(out_load)
  );

  cbs_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS),
                 .CNT_BITS(CNT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .px(in_tdata[COORD_BITS-1:0]), .py(in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .pz(in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .cx(cx), .cy(cy), .cz(cz), .radius(radius), .count(count), .dropped(dropped)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (out_load) ov_r <= 1'b1;
    else if (out_fire) ov_r <= 1'b0;
    if (out_load) od_r <= OB'({dropped, count, radius, cz, cy, cx});
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
endmodule
